// File: rtl/kvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvm_pkg
// shared types and constants for the key to handle map table
// ----------------------------------------------------------------------------
package kvm_pkg;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;

    // request kinds, code 3 is unused and treated as a no-op
    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_SET    = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_e_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] tile;
        status_e_t           status;
    } result_t;

endpackage

// File: rtl/kvm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module kvm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/kvm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvm_ctrl
// request sequencer: scans the entry ram, updates or appends, clears, forms result
// ----------------------------------------------------------------------------
module kvm_ctrl #(
    parameter int ENTRIES = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_fire,
    input  logic [kvm_pkg::REQ_W-1:0]                 req_type,
    input  logic [kvm_pkg::KEY_W-1:0]                 entity_key,
    input  logic [kvm_pkg::HANDLE_W-1:0]              tile_handle,
    input  logic                                      out_free,
    input  logic [kvm_pkg::KEY_W+kvm_pkg::HANDLE_W-1:0] rd_data,
    output logic                                      busy,
    output logic                                      rd_en,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output logic                                      wr_en,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    output logic [kvm_pkg::KEY_W+kvm_pkg::HANDLE_W-1:0] wr_data,
    output logic                                      res_valid,
    output kvm_pkg::result_t                          res
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KW    = kvm_pkg::KEY_W;
    localparam int HW    = kvm_pkg::HANDLE_W;

    kvm_pkg::state_e_t     state_reg, state_next;
    logic [kvm_pkg::REQ_W-1:0] req_reg, req_next;
    logic [KW-1:0]         key_reg, key_next;
    logic [HW-1:0]         handle_reg, handle_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    kvm_pkg::result_t      res_reg, res_next;

    logic                  hit;

    assign hit = chk_valid_reg && (rd_data[KW+HW-1:HW] == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvm_pkg::S_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        handle_reg  <= handle_next;
        rd_ptr_reg  <= rd_ptr_next;
        chk_idx_reg <= chk_idx_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        handle_next    = handle_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_ptr_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_data        = {key_reg, handle_reg};
        res_valid      = 1'b0;

        case (state_reg)
            kvm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next        = req_type;
                    key_next        = entity_key;
                    handle_next     = tile_handle;
                    rd_ptr_next     = '0;
                    res_next.found  = 1'b0;
                    res_next.tile   = '0;
                    res_next.status = kvm_pkg::ST_OK;
                    case (req_type)
                        kvm_pkg::REQ_LOOKUP,
                        kvm_pkg::REQ_SET:
                        begin
                            state_next = kvm_pkg::S_SCAN;
                        end
                        kvm_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = kvm_pkg::S_DONE;
                        end
                        default:
                        begin
                            state_next = kvm_pkg::S_DONE;
                        end
                    endcase
                end
            end

            kvm_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    // first match ends the scan
                    res_next.found = 1'b1;
                    if (req_reg == kvm_pkg::REQ_LOOKUP)
                    begin
                        res_next.tile = rd_data[HW-1:0];
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = chk_idx_reg;
                    end
                    state_next = kvm_pkg::S_DONE;
                end
                else if (rd_ptr_reg < count_reg)
                begin
                    // issue next read, compare lands in the next cycle
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next    = rd_ptr_reg + CNT_W'(1);
                end
                else
                begin
                    // no match among valid entries
                    if (req_reg == kvm_pkg::REQ_LOOKUP)
                    begin
                        res_next.status = kvm_pkg::ST_MISS;
                    end
                    else if (count_reg == CNT_W'(ENTRIES))
                    begin
                        res_next.status = kvm_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = kvm_pkg::S_DONE;
                end
            end

            kvm_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (out_free)
                begin
                    state_next = kvm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kvm_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != kvm_pkg::S_IDLE);
    assign res  = res_reg;

endmodule

// File: rtl/key_to_handle_map_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_to_handle_map_table
// associative table mapping 8-bit entity keys to 16-bit tile handles
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_stall  | req_type, entity_key, tile_handle
//  out     | output    | out_valid/out_stall| found, tile_out, status
//
//  scan: a lookup miss or a set that appends or finds the table full walks
//    every valid entry of the entry ram, one entry per cycle, each read
//    registered before its compare; a hit ends the scan early; clear and
//    unused codes skip the scan and go straight to the result
//  one request is in flight at a time; in_stall is high while it is worked
//    and while its result waits to enter the output register
//  reset clears the entry count, sequencer state and output valid flag;
//    ram contents are left as they are and never read before being written
//  out_stall holds the output register; the next request can be taken
//    while a result waits there
// ----------------------------------------------------------------------------
module key_to_handle_map_table #(
    parameter int ENTRIES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kvm_pkg::REQ_W-1:0]     req_type,
    input  logic [kvm_pkg::KEY_W-1:0]     entity_key,
    input  logic [kvm_pkg::HANDLE_W-1:0]  tile_handle,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [kvm_pkg::HANDLE_W-1:0]  tile_out,
    output logic [kvm_pkg::STATUS_W-1:0]  status
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W = kvm_pkg::KEY_W + kvm_pkg::HANDLE_W;

    logic                  in_fire;
    logic                  busy;
    logic                  out_free;
    // entry ram port signals, one word holds {key, handle}
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_W-1:0]     wr_data;
    // finished result from the sequencer
    logic                  res_valid;
    kvm_pkg::result_t      res;
    // output register
    logic                  out_valid_reg;
    kvm_pkg::result_t      out_res_reg;

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    // output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    kvm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kvm_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .req_type    (req_type),
        .entity_key  (entity_key),
        .tile_handle (tile_handle),
        .out_free    (out_free),
        .rd_data     (rd_data),
        .busy        (busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // output register, parts the result channel from the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_res_reg.found;
    assign tile_out  = out_res_reg.tile;
    assign status    = out_res_reg.status;

endmodule

// File: rtl/kvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvm_checker
// port level checks for the key to handle map table
// ----------------------------------------------------------------------------
module kvm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          found,
    input  logic [kvm_pkg::HANDLE_W-1:0]  tile_out,
    input  logic [kvm_pkg::STATUS_W-1:0]  status
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(found) && $stable(tile_out) && $stable(status))
        else $error("stalled result changed");

    // one request at a time: a transfer closes the input until it is done
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while one is in flight");

    // a hit always reports success
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == kvm_pkg::ST_OK)
        else $error("hit with error status");

    // error results carry no handle and no hit
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != kvm_pkg::ST_OK |-> !found && tile_out == '0)
        else $error("error result with handle or hit");

endmodule

bind key_to_handle_map_table kvm_checker u_kvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .tile_out  (tile_out),
    .status    (status)
);
